/* src/rrts_pkg.sv */
package rrts_pkg;

  // Command codes carried in the kind field
  typedef enum logic [2:0] {
    K_CREATE   = 3'd0,
    K_DELETE   = 3'd1,
    K_SUSPEND  = 3'd2,
    K_RESUME   = 3'd3,
    K_DISPATCH = 3'd4,
    K_SLEEP    = 3'd5,
    K_TICK     = 3'd6,
    K_QUERY    = 3'd7
  } kind_t;

  // Life cycle of one thread slot
  typedef enum logic [1:0] {
    SL_DEAD    = 2'd0,
    SL_READY   = 2'd1,
    SL_RUN     = 2'd2,
    SL_SUSP    = 2'd3
  } slot_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_HALT    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  // Operations of the shared counter unit
  typedef enum logic {
    ALU_ADD_SAT = 1'b0,
    ALU_SUB     = 1'b1
  } alu_op_t;

  // Command sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CUR_RD,
    S_CUR_LD,
    S_CUR_SLP,
    S_CUR_EL,
    S_CUR_RUN,
    S_CUR_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_PICK_EL,
    S_PICK_WAIT,
    S_PICK_BURST,
    S_TGT_RD,
    S_TGT_MOD,
    S_WR,
    S_DONE
  } seq_state_t;

endpackage

/* src/round_robin_thread_scheduler.sv */
// Round-robin thread scheduler. Each command on the in_ stream gives exactly one result on
// the out_ stream. All per-slot counters (stamp, bursts, run, wait, sleep) live in one RAM
// row per slot next to the slot state; a valid bit per row makes unwritten rows read as
// dead with zero counters, so no clearing pass follows reset. One command is taken at a
// time. Create walks the slots from slot 0 to find a dead one; dispatch and sleep first
// demote the current slot, then walk on from the slot after it to find a ready one. A tick
// with no current slot, or a slot id out of range, goes straight to its result. The walk
// reads and checks one slot at a time, and every per-slot counter update shares the single
// add/subtract unit (saturating add, wrapping subtract). A finished result may wait in the
// output register while the next command is taken; a second finished result waits until
// that register is free.
module round_robin_thread_scheduler #(
  parameter int SLOTS      = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // Command stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // kind[2:0], thread_id[6:3], sleep_amount[22:7]
  // Result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata   // status[1:0], result_id[5:2], slot_state[7:6],
                                   // live_threads[12:8], burst_total[44:13],
                                   // run_ticks[76:45], wait_ticks[108:77],
                                   // sleep_ticks[140:109]
);

  localparam int CB    = COUNT_BITS;
  localparam int SW    = $clog2(SLOTS);
  localparam int LW    = $clog2(SLOTS + 1);
  localparam int ROW_W = 2 + 5 * CB;
  localparam int AW    = (CB > 16) ? CB : 16;

  // Clamp a counter to the 32-bit result field
  function automatic logic [31:0] sat32(input logic [63:0] v);
    sat32 = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // Command fields
  rrts_pkg::kind_t in_kind;
  logic [3:0]      in_tid;
  logic [15:0]     in_amt;
  logic            in_fire;
  logic            id_ok;

  assign in_kind = rrts_pkg::kind_t'(in_tdata[2:0]);
  assign in_tid  = in_tdata[6:3];
  assign in_amt  = in_tdata[22:7];
  assign in_fire = in_tvalid && in_tready;
  assign id_ok   = (SLOTS > 16) || (int'(in_tid) < SLOTS);

  // Sequencer and control registers
  rrts_pkg::seq_state_t st_r, st_nxt;
  rrts_pkg::kind_t      kind_r, kind_nxt;
  logic [15:0]          amt_r, amt_nxt;
  logic [SW-1:0]        idx_r, idx_nxt;
  logic [SW-1:0]        cnt_r, cnt_nxt;
  logic [SW-1:0]        cur_r, cur_nxt;
  logic                 cur_valid_r, cur_valid_nxt;
  logic [LW-1:0]        live_r, live_nxt;
  logic [CB-1:0]        now_r, now_nxt;
  logic [SLOTS-1:0]     valid_r, valid_nxt;
  logic                 show_r, show_nxt;
  rrts_pkg::status_t    status_r, status_nxt;
  logic [3:0]           res_id_r, res_id_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [143:0]         out_data_r, out_data_nxt;

  // Working copy of one slot row
  rrts_pkg::slot_t      row_state_r, row_state_nxt;
  logic [CB-1:0]        row_stamp_r, row_stamp_nxt;
  logic [CB-1:0]        row_burst_r, row_burst_nxt;
  logic [CB-1:0]        row_run_r, row_run_nxt;
  logic [CB-1:0]        row_wait_r, row_wait_nxt;
  logic [CB-1:0]        row_sleep_r, row_sleep_nxt;
  logic [CB-1:0]        acc_r, acc_nxt;

  // RAM and shared unit hookup
  logic                 ram_we;
  logic [ROW_W-1:0]     ram_wdata;
  logic [ROW_W-1:0]     ram_rdata;
  rrts_pkg::alu_op_t    alu_op;
  logic [CB-1:0]        alu_a, alu_b, alu_y;

  // Row as read, with unwritten rows shown as dead and zero
  rrts_pkg::slot_t      rd_state;
  logic [CB-1:0]        rd_stamp, rd_burst, rd_run, rd_wait, rd_sleep;
  logic                 rd_valid;
  logic [AW-1:0]        amt_ext;
  logic [CB-1:0]        amt_sat;
  logic [SW-1:0]        idx_inc;
  logic                 scan_hit;

  assign rd_valid = valid_r[idx_r];
  assign rd_state = rd_valid ? rrts_pkg::slot_t'(ram_rdata[1:0]) : rrts_pkg::SL_DEAD;
  assign rd_stamp = rd_valid ? ram_rdata[2 +: CB] : '0;
  assign rd_burst = rd_valid ? ram_rdata[2 + CB +: CB] : '0;
  assign rd_run   = rd_valid ? ram_rdata[2 + 2 * CB +: CB] : '0;
  assign rd_wait  = rd_valid ? ram_rdata[2 + 3 * CB +: CB] : '0;
  assign rd_sleep = rd_valid ? ram_rdata[2 + 4 * CB +: CB] : '0;

  assign ram_wdata = {row_sleep_r, row_wait_r, row_run_r, row_burst_r, row_stamp_r,
                      row_state_r};

  // Sleep amount clamped to counter range so the add still saturates
  assign amt_ext = AW'(amt_r);
  assign amt_sat = (amt_ext > AW'({CB{1'b1}})) ? '1 : CB'(amt_ext);

  assign idx_inc  = (idx_r == SW'(SLOTS - 1)) ? '0 : idx_r + 1'b1;
  assign scan_hit = (kind_r == rrts_pkg::K_CREATE) ? (rd_state == rrts_pkg::SL_DEAD)
                                                   : (rd_state == rrts_pkg::SL_READY);

  rrts_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  rrts_alu #(
    .COUNT_BITS (CB)
  ) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  assign in_tready  = (st_r == rrts_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rrts_pkg::S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      cur_valid_r <= 1'b0;
      live_r      <= '0;
      now_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      cur_valid_r <= cur_valid_nxt;
      live_r      <= live_nxt;
      now_r       <= now_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    amt_r       <= amt_nxt;
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    show_r      <= show_nxt;
    status_r    <= status_nxt;
    res_id_r    <= res_id_nxt;
    out_data_r  <= out_data_nxt;
    row_state_r <= row_state_nxt;
    row_stamp_r <= row_stamp_nxt;
    row_burst_r <= row_burst_nxt;
    row_run_r   <= row_run_nxt;
    row_wait_r  <= row_wait_nxt;
    row_sleep_r <= row_sleep_nxt;
    acc_r       <= acc_nxt;
  end

  // Next state and datapath control
  always_comb begin
    st_nxt        = st_r;
    kind_nxt      = kind_r;
    amt_nxt       = amt_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    live_nxt      = live_r;
    now_nxt       = now_r;
    valid_nxt     = valid_r;
    show_nxt      = show_r;
    status_nxt    = status_r;
    res_id_nxt    = res_id_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    row_state_nxt = row_state_r;
    row_stamp_nxt = row_stamp_r;
    row_burst_nxt = row_burst_r;
    row_run_nxt   = row_run_r;
    row_wait_nxt  = row_wait_r;
    row_sleep_nxt = row_sleep_r;
    acc_nxt       = acc_r;
    ram_we        = 1'b0;
    alu_op        = rrts_pkg::ALU_ADD_SAT;
    alu_a         = '0;
    alu_b         = '0;

    unique case (st_r)
      // Take a command and pick the first step
      rrts_pkg::S_IDLE: begin
        if (in_fire) begin
          kind_nxt   = in_kind;
          amt_nxt    = in_amt;
          show_nxt   = 1'b1;
          status_nxt = rrts_pkg::ST_OK;
          res_id_nxt = in_tid;
          cnt_nxt    = '0;
          unique case (in_kind)
            rrts_pkg::K_CREATE: begin
              idx_nxt = '0;
              st_nxt  = rrts_pkg::S_SCAN_RD;
            end
            rrts_pkg::K_DISPATCH, rrts_pkg::K_SLEEP: begin
              if (cur_valid_r) begin
                idx_nxt = cur_r;
                st_nxt  = rrts_pkg::S_CUR_RD;
              end else begin
                idx_nxt = '0;
                st_nxt  = rrts_pkg::S_SCAN_RD;
              end
            end
            rrts_pkg::K_TICK: begin
              now_nxt = now_r + 1'b1;
              if (cur_valid_r) begin
                idx_nxt = cur_r;
                st_nxt  = rrts_pkg::S_TGT_RD;
              end else begin
                show_nxt   = 1'b0;
                res_id_nxt = '0;
                st_nxt     = rrts_pkg::S_DONE;
              end
            end
            rrts_pkg::K_DELETE, rrts_pkg::K_SUSPEND, rrts_pkg::K_RESUME,
            rrts_pkg::K_QUERY: begin
              if (id_ok) begin
                idx_nxt = SW'(in_tid);
                st_nxt  = rrts_pkg::S_TGT_RD;
              end else begin
                show_nxt = 1'b0;
                st_nxt   = rrts_pkg::S_DONE;
              end
            end
            default: st_nxt = rrts_pkg::S_DONE;
          endcase
        end
      end

      // Demote the current slot before the search
      rrts_pkg::S_CUR_RD: st_nxt = rrts_pkg::S_CUR_LD;
      rrts_pkg::S_CUR_LD: begin
        row_state_nxt = rd_state;
        row_stamp_nxt = rd_stamp;
        row_burst_nxt = rd_burst;
        row_run_nxt   = rd_run;
        row_wait_nxt  = rd_wait;
        row_sleep_nxt = rd_sleep;
        if (rd_state == rrts_pkg::SL_DEAD) begin
          idx_nxt = idx_inc;
          cnt_nxt = '0;
          st_nxt  = rrts_pkg::S_SCAN_RD;
        end else if (kind_r == rrts_pkg::K_SLEEP) begin
          st_nxt = rrts_pkg::S_CUR_SLP;
        end else begin
          st_nxt = rrts_pkg::S_CUR_EL;
        end
      end
      rrts_pkg::S_CUR_SLP: begin
        alu_op        = rrts_pkg::ALU_ADD_SAT;
        alu_a         = row_sleep_r;
        alu_b         = amt_sat;
        row_sleep_nxt = alu_y;
        st_nxt        = rrts_pkg::S_CUR_EL;
      end
      rrts_pkg::S_CUR_EL: begin
        alu_op  = rrts_pkg::ALU_SUB;
        alu_a   = now_r;
        alu_b   = row_stamp_r;
        acc_nxt = alu_y;
        st_nxt  = rrts_pkg::S_CUR_RUN;
      end
      rrts_pkg::S_CUR_RUN: begin
        alu_op        = rrts_pkg::ALU_ADD_SAT;
        alu_a         = row_run_r;
        alu_b         = acc_r;
        row_run_nxt   = alu_y;
        row_state_nxt = rrts_pkg::SL_READY;
        row_stamp_nxt = now_r;
        st_nxt        = rrts_pkg::S_CUR_WR;
      end
      rrts_pkg::S_CUR_WR: begin
        ram_we           = 1'b1;
        valid_nxt[idx_r] = 1'b1;
        idx_nxt          = idx_inc;
        cnt_nxt          = '0;
        st_nxt           = rrts_pkg::S_SCAN_RD;
      end

      // Walk the slots, one read and one check per slot
      rrts_pkg::S_SCAN_RD: st_nxt = rrts_pkg::S_SCAN_CHK;
      rrts_pkg::S_SCAN_CHK: begin
        if (scan_hit) begin
          row_state_nxt = rd_state;
          row_stamp_nxt = rd_stamp;
          row_burst_nxt = rd_burst;
          row_run_nxt   = rd_run;
          row_wait_nxt  = rd_wait;
          row_sleep_nxt = rd_sleep;
          if (kind_r == rrts_pkg::K_CREATE) begin
            row_state_nxt = rrts_pkg::SL_READY;
            row_stamp_nxt = now_r;
            live_nxt      = live_r + 1'b1;
            st_nxt        = rrts_pkg::S_WR;
          end else begin
            st_nxt = rrts_pkg::S_PICK_EL;
          end
        end else if (cnt_r == SW'(SLOTS - 1)) begin
          show_nxt   = 1'b0;
          res_id_nxt = '0;
          if (kind_r == rrts_pkg::K_CREATE) begin
            status_nxt = rrts_pkg::ST_NO_FREE;
          end else begin
            status_nxt    = rrts_pkg::ST_HALT;
            cur_valid_nxt = 1'b0;
            cur_nxt       = '0;
          end
          st_nxt = rrts_pkg::S_DONE;
        end else begin
          idx_nxt = idx_inc;
          cnt_nxt = cnt_r + 1'b1;
          st_nxt  = rrts_pkg::S_SCAN_RD;
        end
      end

      // Promote the chosen slot to running
      rrts_pkg::S_PICK_EL: begin
        alu_op  = rrts_pkg::ALU_SUB;
        alu_a   = now_r;
        alu_b   = row_stamp_r;
        acc_nxt = alu_y;
        st_nxt  = rrts_pkg::S_PICK_WAIT;
      end
      rrts_pkg::S_PICK_WAIT: begin
        alu_op       = rrts_pkg::ALU_ADD_SAT;
        alu_a        = row_wait_r;
        alu_b        = acc_r;
        row_wait_nxt = alu_y;
        st_nxt       = rrts_pkg::S_PICK_BURST;
      end
      rrts_pkg::S_PICK_BURST: begin
        alu_op        = rrts_pkg::ALU_ADD_SAT;
        alu_a         = row_burst_r;
        alu_b         = CB'(1);
        row_burst_nxt = alu_y;
        row_state_nxt = rrts_pkg::SL_RUN;
        row_stamp_nxt = now_r;
        cur_nxt       = idx_r;
        cur_valid_nxt = 1'b1;
        st_nxt        = rrts_pkg::S_WR;
      end

      // Read of one addressed slot, written back for delete, suspend and resume
      rrts_pkg::S_TGT_RD: st_nxt = rrts_pkg::S_TGT_MOD;
      rrts_pkg::S_TGT_MOD: begin
        row_state_nxt = rd_state;
        row_stamp_nxt = rd_stamp;
        row_burst_nxt = rd_burst;
        row_run_nxt   = rd_run;
        row_wait_nxt  = rd_wait;
        row_sleep_nxt = rd_sleep;
        st_nxt        = rrts_pkg::S_WR;
        unique case (kind_r)
          rrts_pkg::K_DELETE: begin
            if (rd_state != rrts_pkg::SL_DEAD) begin
              row_state_nxt = rrts_pkg::SL_DEAD;
              live_nxt      = live_r - 1'b1;
            end
          end
          rrts_pkg::K_SUSPEND: begin
            if (rd_state == rrts_pkg::SL_READY || rd_state == rrts_pkg::SL_RUN) begin
              row_state_nxt = rrts_pkg::SL_SUSP;
            end
          end
          rrts_pkg::K_RESUME: begin
            if (rd_state == rrts_pkg::SL_SUSP) begin
              row_state_nxt = rrts_pkg::SL_READY;
            end
          end
          default: st_nxt = rrts_pkg::S_DONE;
        endcase
      end

      // Write back the working row
      rrts_pkg::S_WR: begin
        ram_we           = 1'b1;
        valid_nxt[idx_r] = 1'b1;
        st_nxt           = rrts_pkg::S_DONE;
      end

      // Hand the result to the output register once it is free
      rrts_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt           = '0;
          out_data_nxt[1:0]      = status_r;
          out_data_nxt[12:8]     = 5'(live_r);
          if (show_r) begin
            out_data_nxt[5:2]     = 4'(idx_r);
            out_data_nxt[7:6]     = row_state_r;
            out_data_nxt[44:13]   = sat32(64'(row_burst_r));
            out_data_nxt[76:45]   = sat32(64'(row_run_r));
            out_data_nxt[108:77]  = sat32(64'(row_wait_r));
            out_data_nxt[140:109] = sat32(64'(row_sleep_r));
          end else begin
            out_data_nxt[5:2]     = res_id_r;
          end
          st_nxt = rrts_pkg::S_IDLE;
        end
      end

      default: st_nxt = rrts_pkg::S_IDLE;
    endcase
  end

  // Live count never exceeds the slot table
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= LW'(SLOTS))
    else $error("live count above slot count");

  // Only one command in flight: no accept right after an accept
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("command accepted while busy");

  // A new result appears only out of the final sequencer step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == rrts_pkg::S_DONE))
    else $error("result raised outside final step");

  // A halt result always leaves no current slot behind it
  a_halt_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == rrts_pkg::S_DONE && status_r == rrts_pkg::ST_HALT) |-> !cur_valid_r)
    else $error("halt with a current slot");

endmodule

/* src/rrts_ram.sv */
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/rrts_alu.sv */
module rrts_alu #(
  parameter int COUNT_BITS = 32
) (
  input  rrts_pkg::alu_op_t       op,
  input  logic [COUNT_BITS-1:0]   a,
  input  logic [COUNT_BITS-1:0]   b,
  output logic [COUNT_BITS-1:0]   y
);

  logic [COUNT_BITS:0] sum;

  // Saturating add for counters, wrapping subtract for elapsed time
  always_comb begin
    sum = {1'b0, a} + {1'b0, b};
    unique case (op)
      rrts_pkg::ALU_ADD_SAT: y = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
      rrts_pkg::ALU_SUB:     y = a - b;
      default:               y = a - b;
    endcase
  end

endmodule
